>>> rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int TERM_W = 2;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_NUL   = 8'h00;

  typedef enum logic [3:0] {
    S_FETCH, S_PUT, S_SCR_RD, S_SCR_WR, S_FILL, S_CLEAR, S_RD_ISSUE, S_RD_CAP, S_DONE
  } step_t;

  typedef enum logic [2:0] {WS_NONE, WS_PUT, WS_RDATA, WS_ZERO, WS_SPACE} wsrc_t;
  typedef enum logic [1:0] {AS_CNT, AS_CURSOR, AS_SRC, AS_INDEX} asel_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} cnt_op_t;
  typedef enum logic [1:0] {CUR_NONE, CUR_PUT, CUR_HOME} cur_op_t;
  typedef enum logic [2:0] {
    C_ALWAYS, C_DISPATCH, C_SCROLL, C_SCR_END, C_SCREEN_END, C_OUT_FREE
  } cond_t;

  typedef struct packed {
    wsrc_t   wsrc;
    asel_t   asel;
    cnt_op_t cnt_op;
    cur_op_t cur_op;
    logic    latch;
    logic    cap_rd;
    logic    out_load;
    cond_t   cond;
    step_t   t_true;
    step_t   t_false;
  } ctl_t;

  typedef struct packed {
    logic            accept;
    logic [OP_W-1:0] op;
    logic            term_ok;
    logic            idx_ok;
    logic            need_scroll;
    logic            scr_end;
    logic            screen_end;
    logic            out_free;
  } status_t;

  typedef struct packed {
    logic              we;
    logic [CHAR_W-1:0] data;
    logic              scroll;
  } put_t;

  // Microprogram: one control word per step.
  function automatic ctl_t ucode(step_t s);
    ctl_t w;
    unique case (s)
      S_FETCH:    w = '{WS_NONE, AS_CNT, CNT_CLR, CUR_NONE, 1'b1, 1'b0, 1'b0,
                        C_DISPATCH, S_FETCH, S_FETCH};
      S_PUT:      w = '{WS_PUT, AS_CURSOR, CNT_CLR, CUR_PUT, 1'b0, 1'b0, 1'b0,
                        C_SCROLL, S_SCR_RD, S_DONE};
      S_SCR_RD:   w = '{WS_NONE, AS_SRC, CNT_HOLD, CUR_NONE, 1'b0, 1'b0, 1'b0,
                        C_ALWAYS, S_SCR_WR, S_SCR_WR};
      S_SCR_WR:   w = '{WS_RDATA, AS_CNT, CNT_INC, CUR_NONE, 1'b0, 1'b0, 1'b0,
                        C_SCR_END, S_FILL, S_SCR_RD};
      S_FILL:     w = '{WS_ZERO, AS_CNT, CNT_INC, CUR_NONE, 1'b0, 1'b0, 1'b0,
                        C_SCREEN_END, S_DONE, S_FILL};
      S_CLEAR:    w = '{WS_SPACE, AS_CNT, CNT_INC, CUR_HOME, 1'b0, 1'b0, 1'b0,
                        C_SCREEN_END, S_DONE, S_CLEAR};
      S_RD_ISSUE: w = '{WS_NONE, AS_INDEX, CNT_HOLD, CUR_NONE, 1'b0, 1'b0, 1'b0,
                        C_ALWAYS, S_RD_CAP, S_RD_CAP};
      S_RD_CAP:   w = '{WS_NONE, AS_INDEX, CNT_HOLD, CUR_NONE, 1'b0, 1'b1, 1'b0,
                        C_ALWAYS, S_DONE, S_DONE};
      S_DONE:     w = '{WS_NONE, AS_CNT, CNT_HOLD, CUR_NONE, 1'b0, 1'b0, 1'b1,
                        C_OUT_FREE, S_FETCH, S_DONE};
      default:    w = '{WS_NONE, AS_CNT, CNT_HOLD, CUR_NONE, 1'b0, 1'b0, 1'b0,
                        C_ALWAYS, S_FETCH, S_FETCH};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/tcw_seq.sv
module tcw_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  tcw_pkg::status_t st,
  output tcw_pkg::ctl_t    ctl,
  output tcw_pkg::step_t   step
);

  tcw_pkg::step_t step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tcw_pkg::S_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    ctl = tcw_pkg::ucode(step_r);
    unique case (ctl.cond)
      tcw_pkg::C_ALWAYS: step_nxt = ctl.t_true;
      tcw_pkg::C_DISPATCH: begin
        priority if (!st.accept) begin
          step_nxt = tcw_pkg::S_FETCH;
        end else if (st.term_ok && st.op == tcw_pkg::OP_PUT) begin
          step_nxt = tcw_pkg::S_PUT;
        end else if (st.term_ok && st.op == tcw_pkg::OP_CLEAR) begin
          step_nxt = tcw_pkg::S_CLEAR;
        end else if (st.term_ok && st.idx_ok && st.op == tcw_pkg::OP_READ) begin
          step_nxt = tcw_pkg::S_RD_ISSUE;
        end else begin
          step_nxt = tcw_pkg::S_DONE;
        end
      end
      tcw_pkg::C_SCROLL:     step_nxt = st.need_scroll ? ctl.t_true : ctl.t_false;
      tcw_pkg::C_SCR_END:    step_nxt = st.scr_end ? ctl.t_true : ctl.t_false;
      tcw_pkg::C_SCREEN_END: step_nxt = st.screen_end ? ctl.t_true : ctl.t_false;
      tcw_pkg::C_OUT_FREE:   step_nxt = st.out_free ? ctl.t_true : ctl.t_false;
      default:               step_nxt = tcw_pkg::S_FETCH;
    endcase
  end

  assign step = step_r;

endmodule

>>> rtl/tcw_cursor.sv
module tcw_cursor #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TERMINALS = 3,
  parameter int CW        = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tcw_pkg::TERM_W-1:0]  term,
  input  logic [tcw_pkg::TERM_W-1:0]  view,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  tcw_pkg::cur_op_t            cur_op,
  output tcw_pkg::put_t               put,
  output logic [CW-1:0]               wr_off,
  output logic [tcw_pkg::POS_W-1:0]   pos
);

  localparam int COLW = $clog2(COLUMNS);
  localparam int ROWW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TIW  = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

  logic [COLW-1:0] col_r [TERMINALS];
  logic [ROWW-1:0] row_r [TERMINALS];

  logic [TIW-1:0]  ti, vi;
  logic [COLW-1:0] c, nc, wcol;
  logic [ROWW-1:0] r, nr, wrow;
  logic [COLW:0]   col_inc;
  logic [ROWW:0]   row_inc, nr_w;
  logic            is_bs, is_nl;
  logic [CW-1:0]   view_lin;

  assign ti = term[TIW-1:0];
  assign vi = view[TIW-1:0];
  assign c  = col_r[ti];
  assign r  = row_r[ti];
  assign col_inc = {1'b0, c} + 1'b1;
  assign row_inc = {1'b0, r} + 1'b1;
  assign is_bs = (char_code == tcw_pkg::CODE_BS);
  assign is_nl = (char_code == tcw_pkg::CODE_LF) || (char_code == tcw_pkg::CODE_CR);

  always_comb begin
    nc       = c;
    nr_w     = {1'b0, r};
    put.we   = 1'b0;
    put.data = char_code;
    wrow     = r;
    wcol     = c;
    if (is_bs) begin
      if (c != '0 || r != '0) begin
        put.we   = 1'b1;
        put.data = tcw_pkg::CODE_SPACE;
        if (c != '0) begin
          nc = c - 1'b1;
        end else begin
          nr_w = {1'b0, r - 1'b1};
          nc   = COLW'(COLUMNS - 1);
        end
        wrow = nr_w[ROWW-1:0];
        wcol = nc;
      end
    end else if (is_nl) begin
      nr_w = row_inc;
      nc   = '0;
    end else begin
      put.we = 1'b1;
      if (col_inc == (COLW+1)'(COLUMNS)) begin
        nc   = '0;
        nr_w = row_inc;
      end else begin
        nc = col_inc[COLW-1:0];
      end
    end
    put.scroll = (nr_w == (ROWW+1)'(ROWS));
    if (put.scroll) begin
      nr = ROWW'(ROWS - 1);
      nc = '0;
    end else begin
      nr = nr_w[ROWW-1:0];
    end
  end

  assign wr_off   = CW'(wrow) * CW'(COLUMNS) + CW'(wcol);
  assign view_lin = CW'(row_r[vi]) * CW'(COLUMNS) + CW'(col_r[vi]);
  assign pos      = (int'(view) < TERMINALS) ? tcw_pkg::POS_W'(view_lin) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TERMINALS; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else begin
      unique case (cur_op)
        tcw_pkg::CUR_PUT: begin
          col_r[ti] <= nc;
          row_r[ti] <= nr;
        end
        tcw_pkg::CUR_HOME: begin
          col_r[ti] <= '0;
          row_r[ti] <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/text_console_writer.sv
// Multi-terminal text console. Items enter on the in_ stream: op (put character,
// clear terminal, read cell), character code, target terminal, visible terminal and
// a cell index for reads. Every accepted item produces exactly one item on the out_
// stream carrying the visible terminal's linear cursor position, the cell read (zero
// unless a read), and a flag set when a put scrolled the screen.
// A small microprogram steps a single-port screen memory and the cursor registers.
// Memory walks: a put that scrolls moves every row up a line over the one memory
// port, so each moved cell takes a read step and a write step, and then fills
// the last row with NUL; a clear writes a space into every cell, one cell
// written per cycle.
// The result is registered: out_tvalid rises at the end of the item's last step.
// A new item is accepted while the previous result still waits; if the receiver
// holds out_tready low, the sequencer waits in its final step until the output
// register frees, and in_tready stays low meanwhile.
// Reset homes every cursor and empties the output register. Screen contents are
// undefined until a terminal is cleared; there is no clearing pass after reset.
module text_console_writer #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TERMINALS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[1:0], char_code[9:2], terminal[11:10], view_terminal[13:12], cell_index[24:14]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cursor_pos[10:0], read_char[18:11], scrolled[19]
  output logic [23:0] out_tdata
);

  localparam int SCREEN = ROWS * COLUMNS;
  localparam int DEPTH  = TERMINALS * SCREEN;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(SCREEN);

  logic [tcw_pkg::OP_W-1:0]   in_op;
  logic [tcw_pkg::CHAR_W-1:0] in_char;
  logic [tcw_pkg::TERM_W-1:0] in_term, in_view;
  logic [tcw_pkg::IDX_W-1:0]  in_idx;

  assign in_op   = in_tdata[1:0];
  assign in_char = in_tdata[9:2];
  assign in_term = in_tdata[11:10];
  assign in_view = in_tdata[13:12];
  assign in_idx  = in_tdata[24:14];

  logic [tcw_pkg::OP_W-1:0]   op_r;
  logic [tcw_pkg::CHAR_W-1:0] char_r;
  logic [tcw_pkg::TERM_W-1:0] term_r, view_r;
  logic [tcw_pkg::IDX_W-1:0]  idx_r;
  logic [CW-1:0]              cnt_r;
  logic [tcw_pkg::CHAR_W-1:0] rd_r, rdata_r;
  logic                       scr_r;

  logic                       out_valid_r;
  logic [tcw_pkg::POS_W-1:0]  pos_o_r;
  logic [tcw_pkg::CHAR_W-1:0] rdc_o_r;
  logic                       scr_o_r;

  tcw_pkg::status_t st;
  tcw_pkg::ctl_t    ctl;
  tcw_pkg::step_t   step;
  tcw_pkg::put_t    put;

  logic [CW-1:0]              wr_off, off;
  logic [tcw_pkg::POS_W-1:0]  pos;
  logic [AW-1:0]              addr;
  logic                       ram_we;
  logic [tcw_pkg::CHAR_W-1:0] ram_wdata;
  logic                       accept, out_free;

  logic [tcw_pkg::CHAR_W-1:0] mem [DEPTH];

  assign in_tready = (step == tcw_pkg::S_FETCH);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign st.accept      = accept;
  assign st.op          = in_op;
  assign st.term_ok     = int'(in_term) < TERMINALS;
  assign st.idx_ok      = int'(in_idx) < SCREEN;
  assign st.need_scroll = put.scroll;
  assign st.scr_end     = (cnt_r == CW'((ROWS - 1) * COLUMNS - 1));
  assign st.screen_end  = (cnt_r == CW'(SCREEN - 1));
  assign st.out_free    = out_free;

  tcw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl),
    .step  (step)
  );

  tcw_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TERMINALS (TERMINALS),
    .CW        (CW)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .term      (term_r),
    .view      (view_r),
    .char_code (char_r),
    .cur_op    (ctl.cur_op),
    .put       (put),
    .wr_off    (wr_off),
    .pos       (pos)
  );

  always_comb begin
    unique case (ctl.asel)
      tcw_pkg::AS_CNT:    off = cnt_r;
      tcw_pkg::AS_CURSOR: off = wr_off;
      tcw_pkg::AS_SRC:    off = cnt_r + CW'(COLUMNS);
      tcw_pkg::AS_INDEX:  off = CW'(idx_r);
      default:            off = cnt_r;
    endcase
  end

  // Each terminal owns a contiguous block of SCREEN cells.
  assign addr = AW'(term_r) * AW'(SCREEN) + AW'(off);

  always_comb begin
    unique case (ctl.wsrc)
      tcw_pkg::WS_PUT: begin
        ram_we    = put.we;
        ram_wdata = put.data;
      end
      tcw_pkg::WS_RDATA: begin
        ram_we    = 1'b1;
        ram_wdata = rdata_r;
      end
      tcw_pkg::WS_ZERO: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::CODE_NUL;
      end
      tcw_pkg::WS_SPACE: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::CODE_SPACE;
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = tcw_pkg::CODE_NUL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      mem[addr] <= ram_wdata;
    end
    rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch && accept) begin
      op_r   <= in_op;
      char_r <= in_char;
      term_r <= in_term;
      view_r <= in_view;
      idx_r  <= in_idx;
      rd_r   <= tcw_pkg::CODE_NUL;
    end else if (ctl.cap_rd) begin
      rd_r <= rdata_r;
    end
    unique case (ctl.cnt_op)
      tcw_pkg::CNT_CLR: cnt_r <= '0;
      tcw_pkg::CNT_INC: cnt_r <= cnt_r + 1'b1;
      default: ;
    endcase
    if (ctl.out_load && out_free) begin
      pos_o_r <= pos;
      rdc_o_r <= rd_r;
      scr_o_r <= scr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.latch && accept) begin
        scr_r <= 1'b0;
      end else if (ctl.cur_op == tcw_pkg::CUR_PUT && put.scroll) begin
        scr_r <= 1'b1;
      end
      if (ctl.out_load && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, scr_o_r, rdc_o_r, pos_o_r};

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ({1'b0, addr} < (AW+1)'(DEPTH)))
    else $error("screen write outside memory");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("item accepted back to back");

  a_scroll_only_put: assert property (@(posedge clk) disable iff (!rst_n)
    scr_r |-> (op_r == tcw_pkg::OP_PUT))
    else $error("scroll flag set for an op other than put");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (step == tcw_pkg::S_DONE && out_free) |=> (out_tvalid && in_tready))
    else $error("finished item did not reach the output register");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int TERMINALS     = 3;
  localparam int SCREEN_CELLS  = ROWS * COLUMNS;
  localparam int ITEM_GOAL     = 1750;
  localparam int MODE_ITEMS    = 150;
  localparam int SCROLL_BUDGET = 40;
  localparam int HOLD_AFTER    = 60;
  localparam int HOLD_CYCLES   = 500;
  localparam int DIRECTED_N    = 24;

  localparam logic [tcw_pkg::OP_W-1:0]   OP_NONE   = 2'd3;
  localparam logic [tcw_pkg::TERM_W-1:0] TERM_NONE = 2'd3;

  typedef enum int {MODE_STEADY, MODE_SLOW_SRC, MODE_SLOW_SINK, MODE_BOTH} traffic_t;

  typedef struct packed {
    logic [tcw_pkg::IDX_W-1:0]  cell_index;
    logic [tcw_pkg::TERM_W-1:0] view;
    logic [tcw_pkg::TERM_W-1:0] term;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::OP_W-1:0]   op;
  } console_cmd_t;

  typedef struct packed {
    logic                       scrolled;
    logic [tcw_pkg::CHAR_W-1:0] read_char;
    logic [tcw_pkg::POS_W-1:0]  cursor_pos;
  } console_res_t;

  typedef struct packed {
    console_cmd_t cmd;
    logic         typed;
    console_res_t res;
  } plan_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [31:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;

  // Shadow copy of every terminal's cursor and screen.
  logic [6:0]                 cur_col [TERMINALS] = '{default: '0};
  logic [4:0]                 cur_row [TERMINALS] = '{default: '0};
  logic [tcw_pkg::CHAR_W-1:0] screen_mem [TERMINALS][SCREEN_CELLS];

  console_res_t pending_res [$];
  traffic_t     mode         = MODE_STEADY;
  int           errors       = 0;
  int           results_seen = 0;
  int           useful_items = 0;
  int           scrolls_left = SCROLL_BUDGET;

  text_console_writer #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TERMINALS(TERMINALS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic console_res_t console_step(console_cmd_t c);
    console_res_t r;
    int t;
    int v;
    int at;
    r = '0;
    t = c.term;
    v = c.view;
    if (t < TERMINALS) begin
      case (c.op)
        tcw_pkg::OP_PUT: begin
          if (c.ch == tcw_pkg::CODE_BS) begin
            if (cur_col[t] != 0 || cur_row[t] != 0) begin
              if (cur_col[t] != 0) begin
                cur_col[t] = cur_col[t] - 7'd1;
              end else begin
                cur_row[t] = cur_row[t] - 5'd1;
                cur_col[t] = 7'(COLUMNS - 1);
              end
              screen_mem[t][cur_row[t] * COLUMNS + cur_col[t]] = tcw_pkg::CODE_SPACE;
            end
          end else begin
            if (c.ch == tcw_pkg::CODE_LF || c.ch == tcw_pkg::CODE_CR) begin
              cur_row[t] = cur_row[t] + 5'd1;
              cur_col[t] = '0;
            end else begin
              screen_mem[t][cur_row[t] * COLUMNS + cur_col[t]] = c.ch;
              if (cur_col[t] == 7'(COLUMNS - 1)) begin
                cur_col[t] = '0;
                cur_row[t] = cur_row[t] + 5'd1;
              end else begin
                cur_col[t] = cur_col[t] + 7'd1;
              end
            end
            // Running off the bottom moves every row up and fills the last one with NUL.
            if (cur_row[t] == 5'(ROWS)) begin
              for (at = 0; at < SCREEN_CELLS - COLUMNS; at++)
                screen_mem[t][at] = screen_mem[t][at + COLUMNS];
              for (at = SCREEN_CELLS - COLUMNS; at < SCREEN_CELLS; at++)
                screen_mem[t][at] = tcw_pkg::CODE_NUL;
              cur_row[t] = 5'(ROWS - 1);
              cur_col[t] = '0;
              r.scrolled = 1'b1;
            end
          end
        end
        tcw_pkg::OP_CLEAR: begin
          for (at = 0; at < SCREEN_CELLS; at++) screen_mem[t][at] = tcw_pkg::CODE_SPACE;
          cur_col[t] = '0;
          cur_row[t] = '0;
        end
        tcw_pkg::OP_READ: begin
          if (c.cell_index < SCREEN_CELLS) r.read_char = screen_mem[t][c.cell_index];
        end
        default: ;
      endcase
    end
    if (v < TERMINALS) r.cursor_pos = tcw_pkg::POS_W'(cur_row[v] * COLUMNS + cur_col[v]);
    return r;
  endfunction

  function automatic console_cmd_t make_cmd(logic [tcw_pkg::OP_W-1:0] op,
                                            logic [tcw_pkg::CHAR_W-1:0] ch,
                                            logic [tcw_pkg::TERM_W-1:0] term,
                                            logic [tcw_pkg::TERM_W-1:0] view,
                                            logic [tcw_pkg::IDX_W-1:0] idx);
    console_cmd_t c;
    c.op         = op;
    c.ch         = ch;
    c.term       = term;
    c.view       = view;
    c.cell_index = idx;
    return c;
  endfunction

  function automatic plan_row_t row_of(logic [tcw_pkg::OP_W-1:0] op,
                                       logic [tcw_pkg::CHAR_W-1:0] ch,
                                       logic [tcw_pkg::TERM_W-1:0] term,
                                       logic [tcw_pkg::TERM_W-1:0] view,
                                       logic [tcw_pkg::IDX_W-1:0] idx, logic typed,
                                       logic [tcw_pkg::POS_W-1:0] pos,
                                       logic [tcw_pkg::CHAR_W-1:0] rd,
                                       logic scr);
    plan_row_t p;
    p.cmd            = make_cmd(op, ch, term, view, idx);
    p.typed          = typed;
    p.res.cursor_pos = pos;
    p.res.read_char  = rd;
    p.res.scrolled   = scr;
    return p;
  endfunction

  // Once the scroll budget is spent, a character that would scroll becomes a backspace,
  // since every scroll walks the whole screen.
  function automatic logic [tcw_pkg::CHAR_W-1:0] capped_char(int t,
                                                             logic [tcw_pkg::CHAR_W-1:0] ch);
    if (scrolls_left == 0 && cur_row[t] == 5'(ROWS - 1) &&
        (ch == tcw_pkg::CODE_LF || ch == tcw_pkg::CODE_CR ||
         (ch != tcw_pkg::CODE_BS && cur_col[t] == 7'(COLUMNS - 1))))
      return tcw_pkg::CODE_BS;
    return ch;
  endfunction

  function automatic logic [tcw_pkg::TERM_W-1:0] pick_view(int t);
    if (roll(8)) return TERM_NONE;
    return roll(50) ? tcw_pkg::TERM_W'(t) : tcw_pkg::TERM_W'($urandom_range(0, TERMINALS - 1));
  endfunction

  // Entered and left at a rising edge; the item is accepted at the edge it returns on.
  task automatic issue_cmd(console_cmd_t c, logic typed = 1'b0, console_res_t typed_res = '0);
    console_res_t r;
    while ((mode == MODE_SLOW_SRC && roll(71)) || (mode == MODE_BOTH && roll(32))) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, c};
    do @(posedge clk); while (!in_tready);
    r = console_step(c);
    if (r.scrolled && scrolls_left > 0) scrolls_left--;
    if (c.op != OP_NONE && c.term < TERMINALS) useful_items++;
    pending_res.push_back(typed ? typed_res : r);
  endtask

  task automatic put_on(int t, logic [tcw_pkg::CHAR_W-1:0] ch);
    issue_cmd(make_cmd(tcw_pkg::OP_PUT, capped_char(t, ch), tcw_pkg::TERM_W'(t), pick_view(t),
                       tcw_pkg::IDX_W'($urandom)));
  endtask

  // Reads a cell shortly behind the cursor, where the last writes landed.
  task automatic read_near(int t);
    int p;
    int idx;
    p = cur_row[t] * COLUMNS + cur_col[t];
    idx = (p >= COLUMNS) ? p - $urandom_range(0, COLUMNS) : $urandom_range(0, COLUMNS - 1);
    issue_cmd(make_cmd(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom), tcw_pkg::TERM_W'(t),
                       pick_view(t), tcw_pkg::IDX_W'(idx)));
  endtask

  initial begin
    plan_row_t    directed_plan [DIRECTED_N];
    console_cmd_t c;
    int           t;
    int           k;
    int           n;

    directed_plan = '{
      row_of(OP_NONE, 8'h00, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_PUT, 8'h41, TERM_NONE, TERM_NONE, 11'd0,
             1'b1, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_READ, 8'hFF, TERM_NONE, 2'd0, 11'd0,
             1'b1, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_CLEAR, 8'h00, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_CLEAR, 8'h00, 2'd1, 2'd1, 11'd0,
             1'b1, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_CLEAR, 8'h00, 2'd2, 2'd2, 11'd0,
             1'b1, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_READ, 8'h00, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd0, tcw_pkg::CODE_SPACE, 1'b0),
      row_of(tcw_pkg::OP_READ, 8'h00, 2'd2, 2'd0, 11'd1999,
             1'b1, 11'd0, tcw_pkg::CODE_SPACE, 1'b0),
      row_of(tcw_pkg::OP_READ, 8'h00, 2'd1, 2'd0, 11'd2047,
             1'b1, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_PUT, tcw_pkg::CODE_BS, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_PUT, 8'hFF, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd1, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_PUT, 8'h00, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd2, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_READ, 8'h00, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd2, 8'hFF, 1'b0),
      row_of(tcw_pkg::OP_READ, 8'h00, 2'd0, 2'd0, 11'd1,
             1'b1, 11'd2, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_PUT, tcw_pkg::CODE_BS, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd1, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_READ, 8'h00, 2'd0, 2'd0, 11'd1,
             1'b1, 11'd1, tcw_pkg::CODE_SPACE, 1'b0),
      row_of(tcw_pkg::OP_PUT, tcw_pkg::CODE_LF, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd80, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_PUT, tcw_pkg::CODE_BS, 2'd0, 2'd0, 11'd0,
             1'b1, 11'd79, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_READ, 8'h00, 2'd0, 2'd0, 11'd79,
             1'b1, 11'd79, tcw_pkg::CODE_SPACE, 1'b0),
      row_of(tcw_pkg::OP_PUT, tcw_pkg::CODE_CR, 2'd1, 2'd1, 11'd0,
             1'b1, 11'd80, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_PUT, 8'h7A, 2'd1, 2'd0, 11'd0,
             1'b0, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_PUT, 8'h0B, 2'd2, 2'd2, 11'd0,
             1'b0, 11'd0, 8'h00, 1'b0),
      row_of(OP_NONE, 8'hFF, 2'd2, TERM_NONE, 11'd2047,
             1'b1, 11'd0, 8'h00, 1'b0),
      row_of(tcw_pkg::OP_READ, 8'h00, 2'd1, 2'd1, 11'd80,
             1'b1, 11'd81, 8'h7A, 1'b0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i])
      issue_cmd(directed_plan[i].cmd, directed_plan[i].typed, directed_plan[i].res);

    // Every screen has been cleared above, so any in-range read is defined from here on.
    while (useful_items < ITEM_GOAL) begin
      mode = traffic_t'((useful_items / MODE_ITEMS) % 4);
      t = $urandom_range(0, TERMINALS - 1);
      k = $urandom_range(0, 99);
      if (k < 48) begin
        n = roll(30) ? $urandom_range(60, 100) : $urandom_range(1, 40);
        repeat (n) begin
          put_on(t, tcw_pkg::CHAR_W'($urandom));
          if (roll(10)) read_near(t);
        end
        if (roll(80)) put_on(t, roll(50) ? tcw_pkg::CODE_LF : tcw_pkg::CODE_CR);
      end else if (k < 60) begin
        repeat ($urandom_range(1, 100)) put_on(t, tcw_pkg::CODE_BS);
      end else if (k < 73) begin
        repeat ($urandom_range(1, 12)) begin
          if (roll(60)) begin
            read_near(t);
          end else begin
            issue_cmd(make_cmd(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom),
                               tcw_pkg::TERM_W'(t), pick_view(t),
                               tcw_pkg::IDX_W'($urandom_range(0, 2047))));
          end
        end
      end else if (k < 85) begin
        repeat ($urandom_range(5, 30))
          put_on(t, roll(50) ? tcw_pkg::CODE_LF : tcw_pkg::CODE_CR);
      end else if (k < 88) begin
        issue_cmd(make_cmd(tcw_pkg::OP_CLEAR, tcw_pkg::CHAR_W'($urandom), tcw_pkg::TERM_W'(t),
                           pick_view(t), tcw_pkg::IDX_W'($urandom)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          c = make_cmd(tcw_pkg::OP_W'($urandom), tcw_pkg::CHAR_W'($urandom),
                       tcw_pkg::TERM_W'($urandom), tcw_pkg::TERM_W'($urandom),
                       tcw_pkg::IDX_W'($urandom));
          if (c.op == tcw_pkg::OP_PUT && c.term < TERMINALS) c.ch = capped_char(c.term, c.ch);
          issue_cmd(c);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stalls per traffic mode, plus one long hold-off early in the
  // steady stretch so the block backs up into its input.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= !((mode == MODE_SLOW_SINK && roll(71)) || (mode == MODE_BOTH && roll(32)));
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    console_res_t want;
    console_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[19:0];
      results_seen++;
      if (pending_res.size() == 0) begin
        $display("%0t: result %h arrived with none expected", $time, out_tdata);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got.cursor_pos !== want.cursor_pos) begin
          $display("%0t: cursor_pos expected %0d actual %0d", $time, want.cursor_pos,
                   got.cursor_pos);
          errors++;
        end
        if (got.read_char !== want.read_char) begin
          $display("%0t: read_char expected %h actual %h", $time, want.read_char,
                   got.read_char);
          errors++;
        end
        if (got.scrolled !== want.scrolled) begin
          $display("%0t: scrolled expected %b actual %b", $time, want.scrolled, got.scrolled);
          errors++;
        end
        if (out_tdata[23:20] !== 4'h0) begin
          $display("%0t: padding expected 0 actual %h", $time, out_tdata[23:20]);
          errors++;
        end
      end
    end
  end

  initial begin
    #(15_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
